// ===== hdl/pu_pkg.sv =====
package pu_pkg;

   localparam int MAX_ROW_DEF     = 256;
   localparam int SAMPLE_BITS_DEF = 8;

   localparam int CSR_DATA_W = 9;
   localparam int CSR_ADDR_W = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_METHOD     = 2'd0,
      CSR_MODULUS    = 2'd1,
      CSR_ROW_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      METH_LEFT       = 3'd0,
      METH_ABOVE      = 3'd1,
      METH_ABOVE_LEFT = 3'd2,
      METH_PLANE      = 3'd3,
      METH_HALF_VERT  = 3'd4,
      METH_HALF_HORZ  = 3'd5,
      METH_AVERAGE    = 3'd6,
      METH_PASS       = 3'd7
   } method_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_REDUCE,
      ST_DONE
   } state_type;

   localparam logic [2:0]            METHOD_RESET     = METH_LEFT;
   localparam logic [CSR_DATA_W-1:0] MODULUS_RESET    = 9'd256;
   localparam logic [CSR_DATA_W-1:0] ROW_LENGTH_RESET = 9'd256;

endpackage

// ===== hdl/predictive_unfilter_unit.sv =====
// channel   direction  tdata                      tuser
// req_      in         residual                   start_req
// rsp_      out        sample                     -
// csr_      in         index 0 method, 1 modulus, 2 row_length (write only)
//
// one request goes through accept, row memory read and prediction, bit-serial modulo
// reduction with one divisor shift per cycle, and write back, which waits for a free
// output register; method 7 skips the reduction
// a new request is taken while a finished sample still waits in the output register
// reset is synchronous; position restarts at the first row, row memory is not cleared
module predictive_unfilter_unit #(
   parameter int MAX_ROW     = pu_pkg::MAX_ROW_DEF,
   parameter int SAMPLE_BITS = pu_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,   // residual
   input  logic                                req_tuser,   // start_req
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,   // sample
   input  logic                                csr_we,
   input  logic [pu_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [pu_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import pu_pkg::*;

   localparam int S     = SAMPLE_BITS;
   localparam int TW    = ((S + 7) / 8) * 8;
   localparam int CW    = $clog2(MAX_ROW);
   localparam int MW    = S + 1;
   localparam int RW    = 2 * S + 2;
   localparam int SW    = 2 * S + 3;
   localparam int STEPS = S + 2;
   localparam int KW    = $clog2(STEPS);
   localparam int FULL  = 1 << S;

   function automatic logic signed [SW-1:0] halve(input logic signed [SW-1:0] d);
      logic signed [SW-1:0] adj;
      adj = d + ((d < 0) ? SW'(1) : SW'(0));
      return adj >>> 1;
   endfunction

   state_type state_ff, state_in;

   logic [2:0]            method_ff;
   logic [CSR_DATA_W-1:0] modulus_ff;
   logic [CSR_DATA_W-1:0] row_length_ff;

   logic [S-1:0]  row_mem [MAX_ROW];
   logic [S-1:0]  mem_rd_ff;

   logic [S-1:0]  left_ff;
   logic [S-1:0]  above_left_ff;
   logic [CW-1:0] column_ff;
   logic          past_ff;

   logic [S-1:0]  res_ff;
   logic [CW-1:0] col_ff;
   logic          past_item_ff;
   logic [S-1:0]  l_ff;
   logic [S-1:0]  c_ff;
   logic [S-1:0]  above_ff;
   logic [RW-1:0] rem_ff;
   logic [RW-1:0] div_ff;
   logic [KW-1:0] cnt_ff;

   logic          rsp_valid_ff;
   logic [S-1:0]  rsp_data_ff;

   logic          accept;
   logic          out_free;
   logic          finish;
   logic [CW-1:0] cur_col;
   logic          cur_past;
   logic [MW-1:0] m_eff;
   logic [CW:0]   len_eff;
   logic [CW:0]   col_next;
   logic [S-1:0]  above;
   logic [S-1:0]  result;
   logic signed [SW-1:0] ls, as, cs, pred, sum;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff     <= METHOD_RESET;
         modulus_ff    <= MODULUS_RESET;
         row_length_ff <= ROW_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_METHOD:     method_ff     <= csr_wdata[2:0];
            CSR_MODULUS:    modulus_ff    <= csr_wdata;
            CSR_ROW_LENGTH: row_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (modulus_ff == '0 || 32'(modulus_ff) > FULL) begin
         m_eff = MW'(FULL);
      end else begin
         m_eff = MW'(modulus_ff);
      end
      if (row_length_ff == '0 || 32'(row_length_ff) > MAX_ROW) begin
         len_eff = (CW+1)'(MAX_ROW);
      end else begin
         len_eff = (CW+1)'(row_length_ff);
      end
   end

   // control
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;
   assign finish   = (state_ff == ST_DONE) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (method_ff == METH_PASS) ? ST_DONE : ST_REDUCE;
         end
         ST_REDUCE: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // position at the request, start flag restarts the image
   assign cur_col  = req_tuser ? '0 : column_ff;
   assign cur_past = req_tuser ? 1'b0 : past_ff;

   // row memory
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff <= row_mem[cur_col];
      end
      if (finish) begin
         row_mem[col_ff] <= result;
      end
   end

   // prediction
   assign above = past_item_ff ? mem_rd_ff : '0;
   assign ls    = signed'(SW'(l_ff));
   assign as    = signed'(SW'(above));
   assign cs    = signed'(SW'(c_ff));

   always_comb begin
      case (method_ff)
         METH_LEFT:       pred = ls;
         METH_ABOVE:      pred = as;
         METH_ABOVE_LEFT: pred = cs;
         METH_PLANE:      pred = ls + as - cs;
         METH_HALF_VERT:  pred = halve(as - cs) + ls;
         METH_HALF_HORZ:  pred = halve(ls - cs) + as;
         METH_AVERAGE:    pred = halve(ls + as);
         default:         pred = '0;
      endcase
      // offset by modulus << S keeps the sum non-negative
      sum = signed'(SW'(res_ff)) + pred + signed'(SW'(m_eff) << S);
   end

   assign result   = rem_ff[S-1:0];
   assign col_next = {1'b0, col_ff} + (CW+1)'(1);

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff       <= req_tdata[S-1:0];
         col_ff       <= cur_col;
         past_item_ff <= cur_past;
         l_ff         <= (cur_col != '0) ? (req_tuser ? '0 : left_ff) : '0;
         c_ff         <= (cur_col != '0 && cur_past) ? above_left_ff : '0;
      end
      if (state_ff == ST_READ) begin
         above_ff <= above;
         cnt_ff   <= KW'(STEPS - 1);
         div_ff   <= RW'(m_eff) << (S + 1);
         if (method_ff == METH_PASS) begin
            rem_ff <= RW'(res_ff);
         end else begin
            rem_ff <= sum[RW-1:0];
         end
      end
      if (state_ff == ST_REDUCE) begin
         if (rem_ff >= div_ff) begin
            rem_ff <= rem_ff - div_ff;
         end
         div_ff <= div_ff >> 1;
         cnt_ff <= cnt_ff - KW'(1);
      end
   end

   // neighbor and position state
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         above_left_ff <= '0;
         column_ff     <= '0;
         past_ff       <= 1'b0;
      end else if (finish) begin
         left_ff       <= result;
         above_left_ff <= above_ff;
         if (col_next >= len_eff) begin
            column_ff <= '0;
            past_ff   <= 1'b1;
         end else begin
            column_ff <= col_next[CW-1:0];
            past_ff   <= past_item_ff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TW'(rsp_data_ff);

endmodule
